### design/clrls_pkg.sv
// Shared types and constants for the cluster recovery load shedder.
`timescale 1ns / 1ps

package clrls_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_REQ   = 2'd2;

  localparam logic [1:0] REG_MIN_WORKING = 2'd0;
  localparam logic [1:0] REG_HOLD_SEC    = 2'd1;
  localparam logic [1:0] REG_REFRESH_MS  = 2'd2;

  localparam int TIME_W    = 48;
  localparam int COUNT_W   = 16;
  localparam int RAND_W    = 32;
  localparam int CFG_W     = 16;
  localparam int HOLD_MS_W = 26;

  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  localparam logic [CFG_W-1:0]     MIN_WORKING_RST = 16'd1;
  localparam logic [HOLD_MS_W-1:0] HOLD_MS_RST     = 26'd1000;
  localparam logic [CFG_W-1:0]     REFRESH_MS_RST  = 16'd10;

  typedef struct packed {
    logic                is_start;
    logic                is_stop;
    logic                is_req;
    logic [TIME_W-1:0]   now_ms;
    logic [COUNT_W-1:0]  usable_count;
    logic [COUNT_W-1:0]  draw;
  } item_t;

  typedef struct packed {
    logic [HOLD_MS_W-1:0] hold_ms;
    logic [CFG_W-1:0]     refresh_ms;
  } back_cfg_t;

endpackage

### design/cluster_recovery_load_shedder_unit.sv
// Top level of the cluster recovery load shedder: ports, configuration registers, stages.
`timescale 1ns / 1ps

// Sustains one transaction per clock cycle while the output does not stall: the back stage
// updates its state for any command as it takes the item, and the front stage does the one
// 32x16 draw multiply in its own register stage. A result passes through the draw register,
// a queue entry and then the result register. The QUEUE_DEPTH-entry queue between front and
// back absorbs output stalls before the input side backs up. Configuration writes are always
// taken; the hold time is stored converted to milliseconds.
module cluster_recovery_load_shedder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], now_ms[49:2], usable_count[65:50], rand_word[97:66], zero pad[103:98]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reject[0], still_recovering[1], zero pad[7:2]
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [clrls_pkg::CFG_W-1:0]     min_working;
  logic [clrls_pkg::HOLD_MS_W-1:0] hold_ms;
  logic [clrls_pkg::CFG_W-1:0]     refresh_ms;
  clrls_pkg::back_cfg_t            back_cfg;

  logic             f_valid;
  logic             f_ready;
  clrls_pkg::item_t f_item;
  logic             q_valid;
  logic             q_ready;
  clrls_pkg::item_t q_item;
  logic             reject;
  logic             still_recovering;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_working <= clrls_pkg::MIN_WORKING_RST;
      hold_ms     <= clrls_pkg::HOLD_MS_RST;
      refresh_ms  <= clrls_pkg::REFRESH_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clrls_pkg::REG_MIN_WORKING: min_working <= cfg_data;
        clrls_pkg::REG_HOLD_SEC: begin
          hold_ms <= clrls_pkg::HOLD_MS_W'({10'b0, cfg_data}
                   * {16'b0, clrls_pkg::MS_PER_SECOND});
        end
        clrls_pkg::REG_REFRESH_MS:  refresh_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign back_cfg.hold_ms    = hold_ms;
  assign back_cfg.refresh_ms = refresh_ms;

  clrls_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .cmd          (s_axis_tdata[1:0]),
    .now_ms       (s_axis_tdata[49:2]),
    .usable_count (s_axis_tdata[65:50]),
    .rand_word    (s_axis_tdata[97:66]),
    .min_working  (min_working),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_item     (f_item)
  );

  clrls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  clrls_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (back_cfg),
    .in_valid         (q_valid),
    .in_ready         (q_ready),
    .in_item          (q_item),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .reject           (reject),
    .still_recovering (still_recovering)
  );

  assign m_axis_tdata = {6'b0, still_recovering, reject};

  a_reject_implies_recovering: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("shed request reported outside recovery");

  a_hold_ms_conversion: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == clrls_pkg::REG_HOLD_SEC)
    |=> hold_ms == clrls_pkg::HOLD_MS_W'({10'b0, $past(cfg_data)}
                 * {16'b0, clrls_pkg::MS_PER_SECOND}))
    else $error("hold time register not converted to milliseconds");

  a_front_holds_item: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_item))
    else $error("front stage dropped or changed an item while the queue was full");

endmodule

### design/clrls_front.sv
// Front stage: decodes the command and computes the rejection draw.
`timescale 1ns / 1ps

module clrls_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         cmd,
  input  logic [clrls_pkg::TIME_W-1:0]       now_ms,
  input  logic [clrls_pkg::COUNT_W-1:0]      usable_count,
  input  logic [clrls_pkg::RAND_W-1:0]       rand_word,
  input  logic [clrls_pkg::CFG_W-1:0]        min_working,
  output logic                               out_valid,
  input  logic                               out_ready,
  output clrls_pkg::item_t                   out_item
);

  localparam int PROD_W = clrls_pkg::RAND_W + clrls_pkg::CFG_W;

  logic [PROD_W-1:0] product;

  assign in_ready = !out_valid || out_ready;
  assign product  = {{clrls_pkg::CFG_W{1'b0}}, rand_word}
                  * {{clrls_pkg::RAND_W{1'b0}}, min_working};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item.is_start     <= (cmd == clrls_pkg::CMD_START);
      out_item.is_stop      <= (cmd == clrls_pkg::CMD_STOP);
      out_item.is_req       <= (cmd == clrls_pkg::CMD_REQ);
      out_item.now_ms       <= now_ms;
      out_item.usable_count <= usable_count;
      out_item.draw         <= product[PROD_W-1:clrls_pkg::RAND_W];
    end
  end

endmodule

### design/clrls_queue.sv
// Short FIFO between the front and back stages.
`timescale 1ns / 1ps

module clrls_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  clrls_pkg::item_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output clrls_pkg::item_t out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  clrls_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != FULL_CNT);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

### design/clrls_back.sv
// Back stage: recovery state, cache refresh, admission decision and result register.
`timescale 1ns / 1ps

module clrls_back (
  input  logic                  clk,
  input  logic                  rst,
  input  clrls_pkg::back_cfg_t  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  clrls_pkg::item_t      in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  reject,
  output logic                  still_recovering
);

  localparam int TW = clrls_pkg::TIME_W;
  localparam int CW = clrls_pkg::COUNT_W;

  logic          recovering;
  logic [CW-1:0] last_usable;
  logic [TW-1:0] last_change_time;
  logic [CW-1:0] cached_usable;
  logic [TW-1:0] cache_time;

  logic          recovering_next;
  logic [CW-1:0] last_usable_next;
  logic [TW-1:0] last_change_time_next;
  logic [CW-1:0] cached_usable_next;
  logic [TW-1:0] cache_time_next;
  logic          reject_next;

  logic [TW-1:0] cache_age;
  logic [TW-1:0] hold_age;
  logic          refresh_due;
  logic          hold_done;
  logic [CW-1:0] count;
  logic          take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign cache_age   = in_item.now_ms - cache_time;
  assign hold_age    = in_item.now_ms - last_change_time;
  assign refresh_due = (in_item.now_ms >= cache_time)
                    && (cache_age >= {{(TW-clrls_pkg::CFG_W){1'b0}}, cfg.refresh_ms});
  assign hold_done   = (last_usable != '0) && (in_item.now_ms > last_change_time)
                    && (hold_age > {{(TW-clrls_pkg::HOLD_MS_W){1'b0}}, cfg.hold_ms});
  assign count       = refresh_due ? in_item.usable_count : cached_usable;

  always_comb begin
    recovering_next       = recovering;
    last_usable_next      = last_usable;
    last_change_time_next = last_change_time;
    cached_usable_next    = cached_usable;
    cache_time_next       = cache_time;
    reject_next           = 1'b0;
    if (in_item.is_start) begin
      recovering_next = 1'b1;
    end else if (in_item.is_stop) begin
      if (recovering && hold_done) begin
        recovering_next       = 1'b0;
        last_usable_next      = '0;
        last_change_time_next = '0;
      end
    end else if (in_item.is_req && recovering) begin
      if (refresh_due) begin
        cached_usable_next = in_item.usable_count;
        cache_time_next    = in_item.now_ms;
      end
      if (count != last_usable) begin
        last_usable_next      = count;
        last_change_time_next = in_item.now_ms;
      end
      reject_next = (in_item.draw >= count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recovering       <= 1'b0;
      last_usable      <= '0;
      last_change_time <= '0;
      cached_usable    <= '0;
      cache_time       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (take) begin
        recovering       <= recovering_next;
        last_usable      <= last_usable_next;
        last_change_time <= last_change_time_next;
        cached_usable    <= cached_usable_next;
        cache_time       <= cache_time_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      reject           <= reject_next;
      still_recovering <= recovering_next;
    end
  end

endmodule

### verif/tb.sv
// Testbench for the cluster recovery load shedder: admission scoreboard, stimulus, checks.
`timescale 1ns / 1ps

typedef struct packed {
  logic reject;
  logic still_recovering;
} verdict_t;

class shed_scoreboard;
  logic                            recovering;
  logic [clrls_pkg::COUNT_W-1:0]   last_usable;
  logic [clrls_pkg::TIME_W-1:0]    last_change_ms;
  logic [clrls_pkg::COUNT_W-1:0]   cached_usable;
  logic [clrls_pkg::TIME_W-1:0]    cache_ms;
  logic [clrls_pkg::CFG_W-1:0]     min_working;
  logic [clrls_pkg::CFG_W-1:0]     hold_sec;
  logic [clrls_pkg::CFG_W-1:0]     refresh_ms;
  verdict_t                        verdict_q[$];
  int                              errors;

  function new();
    recovering     = 1'b0;
    last_usable    = '0;
    last_change_ms = '0;
    cached_usable  = '0;
    cache_ms       = '0;
    min_working    = 16'd1;
    hold_sec       = 16'd1;
    refresh_ms     = 16'd10;
    errors         = 0;
  endfunction

  function void write_reg(logic [1:0] index, logic [clrls_pkg::CFG_W-1:0] value);
    case (index)
      clrls_pkg::REG_MIN_WORKING: min_working = value;
      clrls_pkg::REG_HOLD_SEC:    hold_sec    = value;
      clrls_pkg::REG_REFRESH_MS:  refresh_ms  = value;
      default: ;
    endcase
  endfunction

  function verdict_t predict_verdict(logic [1:0] cmd, logic [clrls_pkg::TIME_W-1:0] now,
                                     logic [clrls_pkg::COUNT_W-1:0] usable,
                                     logic [clrls_pkg::RAND_W-1:0] rnd);
    verdict_t   v;
    logic [63:0] hold_ms;
    logic [63:0] prod;
    v.reject = 1'b0;
    hold_ms  = 64'(hold_sec) * 64'd1000;
    case (cmd)
      clrls_pkg::CMD_START: recovering = 1'b1;
      clrls_pkg::CMD_STOP: begin
        if (recovering && last_usable != 0 && now > last_change_ms &&
            64'(now - last_change_ms) > hold_ms) begin
          recovering     = 1'b0;
          last_usable    = '0;
          last_change_ms = '0;
        end
      end
      clrls_pkg::CMD_REQ: begin
        if (recovering) begin
          if (now >= cache_ms && 64'(now - cache_ms) >= 64'(refresh_ms)) begin
            cached_usable = usable;
            cache_ms      = now;
          end
          if (cached_usable != last_usable) begin
            last_usable    = cached_usable;
            last_change_ms = now;
          end
          prod     = 64'(rnd) * 64'(min_working);
          v.reject = (prod[63:32] >= 32'(cached_usable));
        end
      end
      default: ;
    endcase
    v.still_recovering = recovering;
    return v;
  endfunction

  function void note_item(logic [103:0] word);
    verdict_q.push_back(predict_verdict(word[1:0], word[49:2], word[65:50], word[97:66]));
  endfunction

  function void check_verdict(logic [7:0] word);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t: unexpected result transaction, actual %h", $time, word);
      errors++;
      return;
    end
    want = verdict_q.pop_front();
    if (word[0] !== want.reject) begin
      $display("%0t: reject mismatch, expected %0b actual %0b", $time, want.reject, word[0]);
      errors++;
    end
    if (word[1] !== want.still_recovering) begin
      $display("%0t: still_recovering mismatch, expected %0b actual %0b",
               $time, want.still_recovering, word[1]);
      errors++;
    end
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction
endclass

module tb;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  shed_scoreboard sb;
  int cycles = 0;
  int ready_mode = 0;
  int mode_left = 0;

  cluster_recovery_load_shedder_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
    if (!rst && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  // receiver: modes of full rate, coin flip, one-in-four and long stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (mode_left % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic drive_item(input logic [1:0] cmd, input logic [47:0] now,
                            input logic [15:0] usable, input logic [31:0] rnd);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, rnd, usable, now, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] mw, input logic [15:0] hold,
                            input logic [15:0] refr);
    drain();
    write_cfg(clrls_pkg::REG_MIN_WORKING, mw);
    write_cfg(clrls_pkg::REG_HOLD_SEC, hold);
    write_cfg(clrls_pkg::REG_REFRESH_MS, refr);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] mw, input logic [15:0] hold,
                           input logic [15:0] refr, input logic [47:0] base, input int quota);
    logic [47:0] now;
    logic [15:0] usable;
    logic [1:0]  cmd;
    int unsigned r;
    int unsigned v;
    int          counted;
    int          burst;
    now     = base;
    usable  = 16'd1;
    counted = 0;
    set_config(mw, hold, refr);
    while (counted < quota) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 10) cmd = clrls_pkg::CMD_START;
        else if (r < 30) cmd = clrls_pkg::CMD_STOP;
        else if (r < 97) cmd = clrls_pkg::CMD_REQ;
        else cmd = CMD_UNUSED;
        r = $urandom_range(0, 15);
        if (r < 10) now = now + 48'($urandom_range(0, 32'(refr) + 32'(refr) / 2 + 5));
        else if (r < 14) now = now + 48'($urandom_range(0, 32'(hold) * 500 + 10));
        else if (r == 14) now = now + 48'(32'(hold) * 1000 + $urandom_range(0, 2000));
        else now = now - 48'($urandom_range(0, 3000));
        r = $urandom_range(0, 15);
        if (r == 0) usable = 16'($urandom);
        else if (r == 1) usable = '0;
        else if (r < 4) begin
          v = $urandom_range(0, 32'(mw) + 2);
          usable = (v > 65535) ? 16'hFFFF : 16'(v);
        end
        drive_item(cmd, now, usable, $urandom);
        if (cmd != CMD_UNUSED) counted++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers
    drive_item(clrls_pkg::CMD_REQ, 48'd0, 16'hFFFF, 32'hFFFF_FFFF);
    drive_item(CMD_UNUSED, 48'd0, 16'd0, 32'd0);
    drive_item(clrls_pkg::CMD_STOP, 48'd0, 16'd0, 32'd0);
    drive_item(clrls_pkg::CMD_START, 48'd0, 16'd0, 32'd0);
    drive_item(clrls_pkg::CMD_REQ, 48'd0, 16'd5, 32'd0);
    drive_item(clrls_pkg::CMD_REQ, 48'd10, 16'd5, 32'hFFFF_FFFF);
    drive_item(clrls_pkg::CMD_STOP, 48'd500, 16'd0, 32'd0);
    drive_item(CMD_UNUSED, 48'd600, 16'hFFFF, 32'hFFFF_FFFF);
    drive_item(clrls_pkg::CMD_STOP, 48'd1011, 16'd0, 32'd0);
    // time goes back; count change recorded at time zero
    drive_item(clrls_pkg::CMD_START, 48'd0, 16'd0, 32'd0);
    drive_item(clrls_pkg::CMD_REQ, 48'd0, 16'd7, 32'h8000_0000);
    drive_item(clrls_pkg::CMD_STOP, 48'd0, 16'd0, 32'd0);
    drive_item(clrls_pkg::CMD_STOP, 48'd1000, 16'd0, 32'd0);
    drive_item(clrls_pkg::CMD_STOP, 48'd1001, 16'd0, 32'd0);

    // min_working zero, refresh on every request
    set_config(16'd0, 16'd65535, 16'd0);
    drive_item(clrls_pkg::CMD_START, TIME_MAX, 16'd0, 32'd0);
    drive_item(clrls_pkg::CMD_REQ, TIME_MAX, 16'd0, 32'hFFFF_FFFF);
    drive_item(clrls_pkg::CMD_REQ, TIME_MAX, 16'hFFFF, 32'hFFFF_FFFF);
    drive_item(clrls_pkg::CMD_STOP, TIME_MAX, 16'd0, 32'd0);

    set_config(16'd65535, 16'd1, 16'd65535);
    drive_item(clrls_pkg::CMD_REQ, TIME_MAX, 16'd1, 32'hFFFF_FFFF);
    drive_item(clrls_pkg::CMD_REQ, TIME_MAX, 16'd1, 32'd0);
    drive_item(clrls_pkg::CMD_STOP, TIME_MAX, 16'd0, 32'd0);

    run_phase(16'd1, 16'd1, 16'd10, 48'd20000, 80);
    run_phase(16'd65535, 16'd1, 16'd0, {16'($urandom), $urandom}, 80);
    run_phase(16'd100, 16'd2, 16'd50, {16'($urandom), $urandom}, 80);
    run_phase(16'd8, 16'd65535, 16'd65535, 48'hFFFF_FFF0_0000, 80);
    run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4)),
              16'($urandom_range(0, 300)), {16'($urandom), $urandom}, 80);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
